// File: rtl/msor_pkg.sv
// Shared types, widths and codes of the MP4 sample offset resolver.
`timescale 1ns / 1ps

package msor_pkg;

	// Table depths
	localparam int GROUP_DEPTH = 256;
	localparam int CHUNK_DEPTH = 4096;
	localparam int GROUP_AW    = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
	localparam int CHUNK_AW    = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;

	// Field widths
	localparam int IDX_W   = 12;
	localparam int FIRST_W = 13;
	localparam int SPC_W   = 32;
	localparam int OFF_W   = 64;
	localparam int SIZE_W  = 32;
	localparam int DUR_W   = 32;
	localparam int GCNT_W  = 9;
	localparam int CCNT_W  = 13;
	localparam int CFG_W   = 64;
	localparam int CFG_IW  = 2;

	// Stream packing
	localparam int IN_RAW_W   = IDX_W + FIRST_W + SPC_W + OFF_W + SIZE_W + DUR_W;
	localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = OFF_W + SIZE_W + DUR_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	localparam int IDX_LSB   = 0;
	localparam int FIRST_LSB = IDX_LSB + IDX_W;
	localparam int SPC_LSB   = FIRST_LSB + FIRST_W;
	localparam int COFF_LSB  = SPC_LSB + SPC_W;
	localparam int SIZE_LSB  = COFF_LSB + OFF_W;
	localparam int DUR_LSB   = SIZE_LSB + SIZE_W;

	// Group memory word: first chunk in the high bits, samples per chunk below
	localparam int GRP_W = FIRST_W + SPC_W;

	// Item kinds carried in tuser
	typedef enum logic [1:0] {
		CMD_LOAD_GROUP = 2'd0,
		CMD_LOAD_CHUNK = 2'd1,
		CMD_START      = 2'd2,
		CMD_SAMPLE     = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] REG_GROUP_COUNT = 2'd0;
	localparam logic [CFG_IW-1:0] REG_CHUNK_COUNT = 2'd1;
	localparam logic [CFG_IW-1:0] REG_FILE_SIZE   = 2'd2;

	// Walk operation held for the memory read cycle
	typedef struct packed {
		logic              busy;
		logic              start;
		logic [SIZE_W-1:0] size;
	} walk_op_t;

endpackage

// File: rtl/msor_ram.sv
// Single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module msor_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, or read into the registered rdata output
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/mp4_sample_offset_resolver.sv
// Top level of the MP4 sample offset resolver.
`timescale 1ns / 1ps
//
// Input stream (s_axis_*): one transaction per item, the item kind in tuser.
// Group loads and chunk offset loads write the sample-to-chunk table and the
// chunk offset table. A start rewinds the walk to chunk 0, group 0. A sample
// gives one output transaction (byte offset, size, duration) unless its
// offset is at or past file_size; after that no sample gives a result until
// the next start.
// Output stream (m_axis_*): the result is registered and shows up the cycle
// after its sample is accepted.
// Throughput: loads and suppressed samples go one per cycle while no walk
// op is busy and, for samples, the output register has room. A sample that
// gives a result, or a start, is a walk op: the walk reads the chunk offset
// and group memories through their registered read and updates the walk
// state in the cycle after, so tready drops behind every walk transaction.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// only while idle; the block does not enforce it. Reset clears the walk
// state, the halted flag and the output valid; the tables hold nothing
// defined until loaded. A stalled receiver holds the result; a further
// sample waits in the input, while loads and starts keep flowing.

module mp4_sample_offset_resolver (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// table_index, first_chunk, samples_per_chunk, chunk_offset,
	// sample_size, sample_duration, zero pad
	input  logic [msor_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [1:0]                      s_axis_tuser,
	// Output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// byte_offset, out_size, out_duration
	output logic [msor_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// Configuration
	input  logic                            cfg_we,
	input  logic [msor_pkg::CFG_IW-1:0]     cfg_index,
	input  logic [msor_pkg::CFG_W-1:0]      cfg_data
);

	localparam int CNW = msor_pkg::CHUNK_AW + 1;
	localparam int GNW = msor_pkg::GROUP_AW + 1;

	// Configuration registers
	logic [msor_pkg::GCNT_W-1:0] group_count_q;
	logic [msor_pkg::CCNT_W-1:0] chunk_count_q;
	logic [msor_pkg::OFF_W-1:0]  file_size_q;

	// Walk state
	logic [msor_pkg::OFF_W-1:0]    cur_off_q;
	logic [msor_pkg::CHUNK_AW-1:0] chunk_pos_q;
	logic [msor_pkg::GROUP_AW-1:0] group_pos_q;
	logic [msor_pkg::SPC_W-1:0]    pkt_q;
	logic [msor_pkg::SPC_W-1:0]    spc_q;
	logic                          halted_q;
	msor_pkg::walk_op_t            op_s1;

	// Output register
	logic                          out_valid_q;
	logic [msor_pkg::OUT_DATA_W-1:0] out_data_q;

	// Input fields
	msor_pkg::cmd_t               in_cmd;
	logic [msor_pkg::IDX_W-1:0]   in_idx;
	logic [msor_pkg::FIRST_W-1:0] in_first;
	logic [msor_pkg::SPC_W-1:0]   in_spc;
	logic [msor_pkg::OFF_W-1:0]   in_coff;
	logic [msor_pkg::SIZE_W-1:0]  in_size;
	logic [msor_pkg::DUR_W-1:0]   in_dur;

	logic accept, suppress, emit, walk_go;
	logic grp_we, chk_we, grp_en, chk_en;
	logic [msor_pkg::GROUP_AW-1:0] grp_addr;
	logic [msor_pkg::CHUNK_AW-1:0] chk_addr;
	logic [msor_pkg::GRP_W-1:0]    grp_rdata;
	logic [msor_pkg::OFF_W-1:0]    chk_rdata;
	logic [msor_pkg::FIRST_W-1:0]  rd_first;
	logic [msor_pkg::SPC_W-1:0]    rd_spc;
	logic [CNW-1:0] n_chunks;
	logic [GNW-1:0] n_groups;
	logic [msor_pkg::SPC_W-1:0] pkt_inc;
	logic last_chunk, group_adv;

	// Unpack the input transaction
	assign in_cmd   = msor_pkg::cmd_t'(s_axis_tuser);
	assign in_idx   = s_axis_tdata[msor_pkg::IDX_LSB +: msor_pkg::IDX_W];
	assign in_first = s_axis_tdata[msor_pkg::FIRST_LSB +: msor_pkg::FIRST_W];
	assign in_spc   = s_axis_tdata[msor_pkg::SPC_LSB +: msor_pkg::SPC_W];
	assign in_coff  = s_axis_tdata[msor_pkg::COFF_LSB +: msor_pkg::OFF_W];
	assign in_size  = s_axis_tdata[msor_pkg::SIZE_LSB +: msor_pkg::SIZE_W];
	assign in_dur   = s_axis_tdata[msor_pkg::DUR_LSB +: msor_pkg::DUR_W];

	// Interlock behind a walk op; samples also need room in the output register
	assign s_axis_tready = !op_s1.busy &&
		(!out_valid_q || m_axis_tready || in_cmd != msor_pkg::CMD_SAMPLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign suppress = halted_q || (cur_off_q >= file_size_q);
	assign emit     = accept && in_cmd == msor_pkg::CMD_SAMPLE && !suppress;
	assign walk_go  = emit || (accept && in_cmd == msor_pkg::CMD_START);

	// Memory ports: loads write, walk ops read the next entries (or entry 0)
	assign grp_we = accept && in_cmd == msor_pkg::CMD_LOAD_GROUP &&
		32'(in_idx) < 32'(msor_pkg::GROUP_DEPTH);
	assign chk_we = accept && in_cmd == msor_pkg::CMD_LOAD_CHUNK &&
		32'(in_idx) < 32'(msor_pkg::CHUNK_DEPTH);
	assign grp_en = grp_we || walk_go;
	assign chk_en = chk_we || walk_go;

	always_comb begin
		if (grp_we) begin
			grp_addr = in_idx[msor_pkg::GROUP_AW-1:0];
		end else if (in_cmd == msor_pkg::CMD_START) begin
			grp_addr = '0;
		end else begin
			grp_addr = group_pos_q + msor_pkg::GROUP_AW'(1);
		end
		if (chk_we) begin
			chk_addr = in_idx[msor_pkg::CHUNK_AW-1:0];
		end else if (in_cmd == msor_pkg::CMD_START) begin
			chk_addr = '0;
		end else begin
			chk_addr = chunk_pos_q + msor_pkg::CHUNK_AW'(1);
		end
	end

	msor_ram #(
		.DEPTH (msor_pkg::GROUP_DEPTH),
		.WIDTH (msor_pkg::GRP_W)
	) u_group_ram (
		.clk   (clk),
		.en    (grp_en),
		.we    (grp_we),
		.addr  (grp_addr),
		.wdata ({in_first, in_spc}),
		.rdata (grp_rdata)
	);

	msor_ram #(
		.DEPTH (msor_pkg::CHUNK_DEPTH),
		.WIDTH (msor_pkg::OFF_W)
	) u_chunk_ram (
		.clk   (clk),
		.en    (chk_en),
		.we    (chk_we),
		.addr  (chk_addr),
		.wdata (in_coff),
		.rdata (chk_rdata)
	);

	assign rd_first = grp_rdata[msor_pkg::GRP_W-1 -: msor_pkg::FIRST_W];
	assign rd_spc   = grp_rdata[msor_pkg::SPC_W-1:0];

	// Effective counts: zero acts as one, large values clamp to the depth
	always_comb begin
		if (chunk_count_q == '0) begin
			n_chunks = CNW'(1);
		end else if (32'(chunk_count_q) > 32'(msor_pkg::CHUNK_DEPTH)) begin
			n_chunks = CNW'(msor_pkg::CHUNK_DEPTH);
		end else begin
			n_chunks = CNW'(chunk_count_q);
		end
		if (group_count_q == '0) begin
			n_groups = GNW'(1);
		end else if (32'(group_count_q) > 32'(msor_pkg::GROUP_DEPTH)) begin
			n_groups = GNW'(msor_pkg::GROUP_DEPTH);
		end else begin
			n_groups = GNW'(group_count_q);
		end
	end

	// Walk update terms
	assign pkt_inc    = (&pkt_q) ? pkt_q : pkt_q + msor_pkg::SPC_W'(1);
	assign last_chunk = ({1'b0, chunk_pos_q} + CNW'(1)) >= n_chunks;
	assign group_adv  = (({1'b0, group_pos_q} + GNW'(1)) < n_groups) &&
		(32'(chunk_pos_q) + 32'd2 == 32'(rd_first));

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= msor_pkg::GCNT_W'(1);
			chunk_count_q <= msor_pkg::CCNT_W'(1);
			file_size_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msor_pkg::REG_GROUP_COUNT: group_count_q <= cfg_data[msor_pkg::GCNT_W-1:0];
				msor_pkg::REG_CHUNK_COUNT: chunk_count_q <= cfg_data[msor_pkg::CCNT_W-1:0];
				msor_pkg::REG_FILE_SIZE:   file_size_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Walk op stage and halted flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1.busy  <= 1'b0;
			op_s1.start <= 1'b0;
			op_s1.size  <= '0;
			halted_q    <= 1'b0;
		end else begin
			op_s1.busy <= walk_go;
			if (walk_go) begin
				op_s1.start <= (in_cmd == msor_pkg::CMD_START);
				op_s1.size  <= in_size;
			end
			if (accept && in_cmd == msor_pkg::CMD_START) begin
				halted_q <= 1'b0;
			end else if (accept && in_cmd == msor_pkg::CMD_SAMPLE && suppress) begin
				halted_q <= 1'b1;
			end
		end
	end

	// Walk state update with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_off_q   <= '0;
			chunk_pos_q <= '0;
			group_pos_q <= '0;
			pkt_q       <= '0;
			spc_q       <= '0;
		end else if (op_s1.busy) begin
			if (op_s1.start) begin
				cur_off_q   <= chk_rdata;
				chunk_pos_q <= '0;
				group_pos_q <= '0;
				pkt_q       <= '0;
				spc_q       <= rd_spc;
			end else if (pkt_inc < spc_q) begin
				cur_off_q <= cur_off_q + 64'(op_s1.size);
				pkt_q     <= pkt_inc;
			end else if (last_chunk) begin
				pkt_q <= pkt_inc;
			end else begin
				// roll over to the next chunk
				cur_off_q   <= chk_rdata;
				chunk_pos_q <= chunk_pos_q + msor_pkg::CHUNK_AW'(1);
				pkt_q       <= '0;
				if (group_adv) begin
					group_pos_q <= group_pos_q + msor_pkg::GROUP_AW'(1);
					spc_q       <= rd_spc;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= msor_pkg::OUT_DATA_W'({in_dur, in_size, cur_off_q});
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/msor_checker.sv
// Port-level checks of the MP4 sample offset resolver, bound to the top level.
`timescale 1ns / 1ps

module msor_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [1:0]                      s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [msor_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// A start holds the walk op stage busy, so input ready drops behind it
	a_start_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser == msor_pkg::CMD_START) |=> !s_axis_tready)
		else $error("input ready while a start is still updating the walk");

	// Loads and starts never create an output transaction
	a_no_result_from_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser != msor_pkg::CMD_SAMPLE &&
		 (!m_axis_tvalid || m_axis_tready)) |=> !m_axis_tvalid)
		else $error("output appeared without a sample");

	// A stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	// A stalled result keeps its data
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output data changed while stalled");

endmodule

bind mp4_sample_offset_resolver msor_checker u_msor_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
